// ----- design/tcse_pkg.sv -----
package tcse_pkg;

  localparam int unsigned Slots = 8;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;

  localparam logic [31:0] IssReset = 32'h0001_0000;
  localparam logic [31:0] IssStep  = 32'd64000;

  localparam logic [7:0] FlFin = 8'h01;
  localparam logic [7:0] FlSyn = 8'h02;
  localparam logic [7:0] FlAck = 8'h10;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_LISTEN  = 2'd1,
    OP_CONNECT = 2'd2,
    OP_CLOSE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CS_CLOSED      = 4'd0,
    CS_LISTEN      = 4'd1,
    CS_SYN_SENT    = 4'd2,
    CS_SYN_RCVD    = 4'd3,
    CS_ESTAB       = 4'd4,
    CS_FIN_WAIT_1  = 4'd5,
    CS_FIN_WAIT_2  = 4'd6,
    CS_CLOSE_WAIT  = 4'd7,
    CS_CLOSING     = 4'd8,
    CS_LAST_ACK    = 4'd9,
    CS_TIME_WAIT   = 4'd10
  } conn_state_e;

  // sequencer states
  typedef enum logic [1:0] {
    SQ_IDLE = 2'd0,
    SQ_READ = 2'd1,
    SQ_EXEC = 2'd2,
    SQ_OUT  = 2'd3
  } seq_state_e;

  // per-slot record kept in the connection memory
  typedef struct packed {
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
    logic [31:0] snd_nxt;
    logic [31:0] snd_una;
    logic [31:0] rcv_nxt;
    logic [31:0] irs;
    logic [31:0] iss;
  } conn_rec_t;

  // per-slot summary kept in flip-flops for matching
  typedef struct packed {
    logic        used;
    conn_state_e cstate;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
  } slot_tag_t;

  // one outgoing control segment
  typedef struct packed {
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
  } ctl_seg_t;

endpackage

// ----- design/tcp_connection_state_engine.sv -----
// Connection table for a TCP offload block. Each item (segment header, listen,
// connect or close) is taken in an idle cycle and then runs three more stages:
// a match stage compares the four-tuple against per-slot tags held in
// flip-flops, picks the slot and issues the read of the slot's record from the
// connection memory; an exec stage runs the state step on the read data and
// writes the record back; an output stage hands out the one or two result
// items, holding each while the output stalls. The next item is taken in the
// idle cycle after the last result is taken. The sequence record memory needs
// no clearing: a slot's record is rewritten on allocation before it is read.
module tcp_connection_state_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] local_ip_i,
  input  logic [15:0] local_port_i,
  input  logic [31:0] remote_ip_i,
  input  logic [15:0] remote_port_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_ack_i,
  input  logic [7:0]  seg_flags_i,
  input  logic [15:0] seg_len_i,
  input  logic [2:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  conn_slot_o,
  output logic [3:0]  new_state_o,
  output logic        send_o,
  output logic [7:0]  send_flags_o,
  output logic [31:0] send_seq_o,
  output logic [31:0] send_ack_o,
  output logic [31:0] out_local_ip_o,
  output logic [15:0] out_local_port_o,
  output logic [31:0] out_remote_ip_o,
  output logic [15:0] out_remote_port_o,
  output logic        last_o
);
  import tcse_pkg::*;

  seq_state_e state_q, state_d;

  // latched item
  op_e         op_q;
  logic [31:0] lip_q, rip_q, seq_q, ack_q;
  logic [15:0] lport_q, rport_q, len_q;
  logic [7:0]  fl_q;
  logic [2:0]  req_q;

  slot_tag_t   tags_q [Slots];
  logic [31:0] iss_q;

  logic [SlotW-1:0] sl_q;
  logic             found_q;
  status_e          status_q;
  conn_state_e      nstate_q;
  ctl_seg_t         seg_q [2];
  logic [1:0]       nseg_q;
  logic             idx_q;

  logic             hit, free;
  logic [SlotW-1:0] hit_slot, free_slot;
  conn_rec_t        rd;
  logic             mem_we;
  conn_rec_t        mem_wd;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  tcse_match u_match (
    .tags_i      (tags_q),
    .lip_i       (lip_q),
    .lport_i     (lport_q),
    .rip_i       (rip_q),
    .rport_i     (rport_q),
    .hit_o       (hit),
    .hit_slot_o  (hit_slot),
    .free_o      (free),
    .free_slot_o (free_slot)
  );

  // slot chosen in the match cycle
  function automatic logic [SlotW-1:0] sel_slot();
    logic [SlotW-1:0] r;
    r = '0;
    case (op_q)
      OP_SEGMENT: r = hit_slot;
      OP_LISTEN, OP_CONNECT: r = free_slot;
      default: r = SlotW'(req_q);
    endcase
    return r;
  endfunction

  tcse_conn_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (sl_q),
    .wdata_i (mem_wd),
    .raddr_i (state_q == SQ_READ ? sel_slot() : sl_q),
    .rdata_o (rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SQ_IDLE: if (in_valid_i) state_d = SQ_READ;
      SQ_READ: state_d = SQ_EXEC;
      SQ_EXEC: state_d = SQ_OUT;
      SQ_OUT: begin
        if (out_acc && (idx_q || nseg_q < 2'd2)) state_d = SQ_IDLE;
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = state_q != SQ_IDLE;
    out_valid_o = state_q == SQ_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_e'(operation_i);
      lip_q   <= local_ip_i;
      lport_q <= local_port_i;
      rip_q   <= remote_ip_i;
      rport_q <= remote_port_i;
      seq_q   <= seg_seq_i;
      ack_q   <= seg_ack_i;
      fl_q    <= seg_flags_i;
      len_q   <= seg_len_i;
      req_q   <= slot_i;
    end
  end

  // match cycle result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      sl_q    <= '0;
    end else if (state_q == SQ_READ) begin
      sl_q <= sel_slot();
      case (op_q)
        OP_SEGMENT: found_q <= hit;
        OP_LISTEN, OP_CONNECT: found_q <= free;
        default: found_q <= ({29'd0, req_q} < 32'(Slots)) &&
                            tags_q[SlotW'(req_q)].used;
      endcase
    end
  end

  // state step: combinational update of the read record
  conn_rec_t   r;
  slot_tag_t   t;
  logic [31:0] iss_n;
  logic        iss_we;
  ctl_seg_t    sg [2];
  logic [1:0]  ns;
  status_e     stat;
  conn_state_e cs;

  always_comb begin
    logic [31:0] nx;
    logic        fin, syn, ackf;
    r = rd;
    t = tags_q[sl_q];
    cs = t.cstate;
    iss_n = iss_q + IssStep;
    iss_we = 1'b0;
    ns = 2'd0;
    sg[0] = '0;
    sg[1] = '0;
    stat = ST_OK;
    mem_we = 1'b0;
    fin = fl_q[0];
    syn = fl_q[1];
    ackf = fl_q[4];
    nx = '0;
    case (op_q)
      OP_SEGMENT: begin
        if (!found_q) begin
          stat = ST_NO_MATCH;
        end else begin
          mem_we = 1'b1;
          if (cs == CS_LISTEN) begin
            r.rip = rip_q;
            r.rport = rport_q;
            r.lip = lip_q;
          end
          case (cs)
            CS_LISTEN: begin
              if (syn) begin
                iss_we = 1'b1;
                r.irs = seq_q;
                r.rcv_nxt = seq_q + 32'd1;
                r.iss = iss_n;
                r.snd_una = iss_n;
                r.snd_nxt = iss_n + 32'd1;
                cs = CS_SYN_RCVD;
                ns = 2'd1;
                sg[0] = '{FlSyn | FlAck, iss_n, seq_q + 32'd1,
                          r.lip, r.lport, r.rip, r.rport};
              end
            end
            CS_SYN_SENT: begin
              if (syn && ackf) begin
                r.irs = seq_q;
                r.rcv_nxt = seq_q + 32'd1;
                r.snd_una = ack_q;
                cs = CS_ESTAB;
                ns = 2'd1;
                sg[0] = '{FlAck, r.snd_nxt, r.rcv_nxt,
                          r.lip, r.lport, r.rip, r.rport};
              end else if (syn) begin
                r.irs = seq_q;
                r.rcv_nxt = seq_q + 32'd1;
                cs = CS_SYN_RCVD;
                ns = 2'd1;
                sg[0] = '{FlSyn | FlAck, r.iss, r.rcv_nxt,
                          r.lip, r.lport, r.rip, r.rport};
              end
            end
            CS_SYN_RCVD: begin
              if (ackf) begin
                r.snd_una = ack_q;
                cs = CS_ESTAB;
              end
            end
            CS_ESTAB: begin
              nx = seq_q + {16'd0, len_q};
              if (len_q != 16'd0) begin
                r.rcv_nxt = nx;
                sg[0] = '{FlAck, r.snd_nxt, nx, r.lip, r.lport, r.rip, r.rport};
                ns = 2'd1;
              end
              if (fin) begin
                r.rcv_nxt = nx + 32'd1;
                cs = CS_CLOSE_WAIT;
                sg[ns[0]] = '{FlAck, r.snd_nxt, nx + 32'd1,
                              r.lip, r.lport, r.rip, r.rport};
                ns = ns + 2'd1;
              end
            end
            CS_FIN_WAIT_1: begin
              if (ackf) cs = CS_FIN_WAIT_2;
              if (fin) begin
                r.rcv_nxt = seq_q + 32'd1;
                cs = ackf ? CS_TIME_WAIT : CS_CLOSING;
                ns = 2'd1;
                sg[0] = '{FlAck, r.snd_nxt, seq_q + 32'd1,
                          r.lip, r.lport, r.rip, r.rport};
              end
            end
            CS_FIN_WAIT_2: begin
              if (fin) begin
                r.rcv_nxt = seq_q + 32'd1;
                cs = CS_TIME_WAIT;
                ns = 2'd1;
                sg[0] = '{FlAck, r.snd_nxt, seq_q + 32'd1,
                          r.lip, r.lport, r.rip, r.rport};
              end
            end
            CS_CLOSING: if (ackf) cs = CS_TIME_WAIT;
            CS_LAST_ACK: begin
              if (ackf) begin
                cs = CS_CLOSED;
                t.used = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_LISTEN, OP_CONNECT: begin
        if (!found_q) begin
          stat = ST_FULL;
        end else begin
          mem_we = 1'b1;
          t.used = 1'b1;
          r = '0;
          r.lip = lip_q;
          r.lport = lport_q;
          if (op_q == OP_LISTEN) begin
            cs = CS_LISTEN;
          end else begin
            iss_we = 1'b1;
            r.rip = rip_q;
            r.rport = rport_q;
            r.iss = iss_n;
            r.snd_una = iss_n;
            r.snd_nxt = iss_n + 32'd1;
            cs = CS_SYN_SENT;
            ns = 2'd1;
            sg[0] = '{FlSyn, iss_n, 32'd0, lip_q, lport_q, rip_q, rport_q};
          end
        end
      end
      default: begin
        if (!found_q) begin
          stat = ST_UNUSED;
        end else begin
          mem_we = 1'b1;
          case (cs)
            CS_ESTAB, CS_CLOSE_WAIT: begin
              sg[0] = '{FlFin | FlAck, r.snd_nxt, r.rcv_nxt,
                        r.lip, r.lport, r.rip, r.rport};
              ns = 2'd1;
              r.snd_nxt = r.snd_nxt + 32'd1;
              cs = (cs == CS_ESTAB) ? CS_FIN_WAIT_1 : CS_LAST_ACK;
            end
            CS_SYN_SENT, CS_SYN_RCVD, CS_LISTEN: cs = CS_CLOSED;
            default: ;
          endcase
        end
      end
    endcase
    // ack segments advance nothing; syn-bearing segments were folded in
    t.cstate = cs;
    t.lip = r.lip;
    t.lport = r.lport;
    t.rip = r.rip;
    t.rport = r.rport;
    mem_wd = r;
    mem_we = mem_we && (state_q == SQ_EXEC);
  end

  // tag table, counter and result capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        tags_q[i].used   <= 1'b0;
        tags_q[i].cstate <= CS_CLOSED;
      end
      iss_q  <= IssReset;
      nseg_q <= '0;
      idx_q  <= 1'b0;
    end else if (state_q == SQ_EXEC) begin
      idx_q  <= 1'b0;
      nseg_q <= ns;
      if (iss_we) iss_q <= iss_n;
      if (found_q) tags_q[sl_q] <= t;
    end else if (state_q == SQ_OUT && out_acc) begin
      idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SQ_EXEC) begin
      status_q <= stat;
      nstate_q <= found_q ? cs : CS_CLOSED;
      seg_q[0] <= sg[0];
      seg_q[1] <= sg[1];
    end
  end

  // result ports
  always_comb begin
    logic [SlotW-1:0] cslot;
    cslot = sl_q;
    status_o    = status_q;
    conn_slot_o = 3'(cslot);
    if (op_q == OP_CLOSE) conn_slot_o = req_q;
    else if (!found_q) conn_slot_o = 3'd0;
    new_state_o = nstate_q;
    send_o = nseg_q != 2'd0;
    last_o = idx_q || nseg_q < 2'd2;
    {send_flags_o, send_seq_o, send_ack_o, out_local_ip_o, out_local_port_o,
     out_remote_ip_o, out_remote_port_o} = seg_q[idx_q];
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item accepted during output");
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && idx_q) |-> nseg_q == 2'd2) else $error("bad second result");
  a_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SQ_EXEC |=> state_q == SQ_OUT) else $error("sequencer skip");
`endif

endmodule

// ----- design/tcse_conn_mem.sv -----
module tcse_conn_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [tcse_pkg::SlotW-1:0]  waddr_i,
  input  tcse_pkg::conn_rec_t         wdata_i,
  input  logic [tcse_pkg::SlotW-1:0]  raddr_i,
  output tcse_pkg::conn_rec_t         rdata_o
);
  import tcse_pkg::*;

  conn_rec_t mem_q [Slots];
  conn_rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tcse_match.sv -----
module tcse_match (
  input  tcse_pkg::slot_tag_t         tags_i [tcse_pkg::Slots],
  input  logic [31:0]                 lip_i,
  input  logic [15:0]                 lport_i,
  input  logic [31:0]                 rip_i,
  input  logic [15:0]                 rport_i,
  output logic                        hit_o,
  output logic [tcse_pkg::SlotW-1:0]  hit_slot_o,
  output logic                        free_o,
  output logic [tcse_pkg::SlotW-1:0]  free_slot_o
);
  import tcse_pkg::*;

  logic [Slots-1:0] exact;
  logic [Slots-1:0] lsn;

  // per-slot tuple compare
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      logic lm;
      lm = (tags_i[i].lip == 32'd0) || (tags_i[i].lip == lip_i);
      exact[i] = tags_i[i].used && tags_i[i].lport == lport_i && lm &&
                 tags_i[i].cstate != CS_LISTEN && tags_i[i].rport == rport_i &&
                 tags_i[i].rip == rip_i;
      lsn[i] = tags_i[i].used && tags_i[i].lport == lport_i && lm &&
               tags_i[i].cstate == CS_LISTEN;
    end
  end

  // lowest exact match, else highest listener
  always_comb begin
    hit_o = 1'b0;
    hit_slot_o = '0;
    for (int i = 0; i < Slots; i++) begin
      if (lsn[i]) begin
        hit_o = 1'b1;
        hit_slot_o = SlotW'(i);
      end
    end
    for (int i = Slots - 1; i >= 0; i--) begin
      if (exact[i]) begin
        hit_o = 1'b1;
        hit_slot_o = SlotW'(i);
      end
    end
  end

  // lowest free slot
  always_comb begin
    free_o = 1'b0;
    free_slot_o = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!tags_i[i].used) begin
        free_o = 1'b1;
        free_slot_o = SlotW'(i);
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  import tcse_pkg::*;

  // one request as offered to the block
  typedef struct {
    op_e         op;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] rip;
    logic [15:0] rport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [15:0] len;
    logic [2:0]  slot;
  } req_t;

  // one expected result item
  typedef struct {
    status_e     status;
    logic [2:0]  slot;
    logic [3:0]  nstate;
    logic        snd;
    ctl_seg_t    seg;
    logic        last;
  } res_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomItems = 1450;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [31:0] local_ip_i = '0;
  logic [15:0] local_port_i = '0;
  logic [31:0] remote_ip_i = '0;
  logic [15:0] remote_port_i = '0;
  logic [31:0] seg_seq_i = '0;
  logic [31:0] seg_ack_i = '0;
  logic [7:0]  seg_flags_i = '0;
  logic [15:0] seg_len_i = '0;
  logic [2:0]  slot_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [2:0]  conn_slot_o;
  logic [3:0]  new_state_o;
  logic        send_o;
  logic [7:0]  send_flags_o;
  logic [31:0] send_seq_o;
  logic [31:0] send_ack_o;
  logic [31:0] out_local_ip_o;
  logic [15:0] out_local_port_o;
  logic [31:0] out_remote_ip_o;
  logic [15:0] out_remote_port_o;
  logic        last_o;

  tcp_connection_state_engine u_top (.*);

  always #5 clk_i = ~clk_i;

  // connection table as predicted
  logic        conn_used[Slots];
  conn_state_e conn_st[Slots];
  conn_rec_t   conn_rec[Slots];
  logic [31:0] isn_counter;
  ctl_seg_t    ctl_out[$];
  res_t        expected_results[$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned segs_seen = 0;
  int unsigned flows_done = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_cycles = 0;
  int unsigned stall_mode = 0;

  function automatic logic [31:0] next_isn();
    isn_counter = isn_counter + IssStep;
    return isn_counter;
  endfunction

  // queue an outgoing control segment, at most two per item
  function automatic void queue_ctl(int s, logic [7:0] fl, logic [31:0] sq);
    ctl_seg_t c;
    if (ctl_out.size() >= 2) return;
    c.flags = fl;
    c.seq   = sq;
    c.ack   = conn_rec[s].rcv_nxt;
    c.lip   = conn_rec[s].lip;
    c.lport = conn_rec[s].lport;
    c.rip   = conn_rec[s].rip;
    c.rport = conn_rec[s].rport;
    ctl_out.push_back(c);
  endfunction

  function automatic void send_ctl(int s, logic [7:0] fl);
    queue_ctl(s, fl, conn_rec[s].snd_nxt);
    if ((fl & FlSyn) != 0) conn_rec[s].snd_nxt += 1;
    if ((fl & FlFin) != 0) conn_rec[s].snd_nxt += 1;
  endfunction

  // exact tuple match first (lowest slot), else highest listener
  function automatic int find_conn(logic [31:0] lip, logic [15:0] lport,
                                   logic [31:0] rip, logic [15:0] rport);
    int lst;
    logic lm;
    lst = -1;
    for (int i = 0; i < Slots; i++) begin
      if (!conn_used[i] || conn_rec[i].lport != lport) continue;
      lm = (conn_rec[i].lip == 0) || (conn_rec[i].lip == lip);
      if (conn_st[i] != CS_LISTEN && conn_rec[i].rport == rport &&
          conn_rec[i].rip == rip && lm) return i;
      if (conn_st[i] == CS_LISTEN && lm) lst = i;
    end
    return lst;
  endfunction

  // state step for an inbound segment on slot s
  function automatic void segment_step(int s, logic [31:0] sq, logic [31:0] ak,
                                       logic [7:0] fl, logic [15:0] len);
    case (conn_st[s])
      CS_LISTEN: begin
        if ((fl & FlSyn) != 0) begin
          conn_rec[s].irs = sq;
          conn_rec[s].rcv_nxt = sq + 1;
          conn_rec[s].iss = next_isn();
          conn_rec[s].snd_una = conn_rec[s].iss;
          conn_rec[s].snd_nxt = conn_rec[s].iss;
          conn_st[s] = CS_SYN_RCVD;
          send_ctl(s, FlSyn | FlAck);
        end
      end
      CS_SYN_SENT: begin
        if ((fl & (FlSyn | FlAck)) == (FlSyn | FlAck)) begin
          conn_rec[s].irs = sq;
          conn_rec[s].rcv_nxt = sq + 1;
          conn_rec[s].snd_una = ak;
          conn_st[s] = CS_ESTAB;
          send_ctl(s, FlAck);
        end else if ((fl & FlSyn) != 0) begin
          // simultaneous open: resend the initial sequence
          conn_rec[s].irs = sq;
          conn_rec[s].rcv_nxt = sq + 1;
          conn_st[s] = CS_SYN_RCVD;
          queue_ctl(s, FlSyn | FlAck, conn_rec[s].iss);
        end
      end
      CS_SYN_RCVD: begin
        if ((fl & FlAck) != 0) begin
          conn_rec[s].snd_una = ak;
          conn_st[s] = CS_ESTAB;
        end
      end
      CS_ESTAB: begin
        if (len != 0) begin
          conn_rec[s].rcv_nxt = sq + {16'd0, len};
          send_ctl(s, FlAck);
        end
        if ((fl & FlFin) != 0) begin
          conn_rec[s].rcv_nxt = sq + {16'd0, len} + 1;
          conn_st[s] = CS_CLOSE_WAIT;
          send_ctl(s, FlAck);
        end
      end
      CS_FIN_WAIT_1: begin
        if ((fl & FlAck) != 0) conn_st[s] = CS_FIN_WAIT_2;
        if ((fl & FlFin) != 0) begin
          conn_rec[s].rcv_nxt = sq + 1;
          conn_st[s] = (conn_st[s] == CS_FIN_WAIT_2) ? CS_TIME_WAIT : CS_CLOSING;
          send_ctl(s, FlAck);
        end
      end
      CS_FIN_WAIT_2: begin
        if ((fl & FlFin) != 0) begin
          conn_rec[s].rcv_nxt = sq + 1;
          conn_st[s] = CS_TIME_WAIT;
          send_ctl(s, FlAck);
        end
      end
      CS_CLOSING: if ((fl & FlAck) != 0) conn_st[s] = CS_TIME_WAIT;
      CS_LAST_ACK: begin
        if ((fl & FlAck) != 0) begin
          conn_st[s] = CS_CLOSED;
          conn_used[s] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // work out the results of one accepted item
  function automatic void predict_results(req_t r);
    int s;
    int n;
    status_e stt;
    logic [2:0] cs;
    conn_state_e ns;
    res_t e;
    ctl_out.delete();
    stt = ST_OK;
    cs = '0;
    ns = CS_CLOSED;
    case (r.op)
      OP_SEGMENT: begin
        s = find_conn(r.lip, r.lport, r.rip, r.rport);
        if (s < 0) stt = ST_NO_MATCH;
        else begin
          if (conn_st[s] == CS_LISTEN) begin
            conn_rec[s].rip = r.rip;
            conn_rec[s].rport = r.rport;
            conn_rec[s].lip = r.lip;
          end
          segment_step(s, r.seq, r.ack, r.flags, r.len);
          cs = s[2:0];
          ns = conn_st[s];
        end
      end
      OP_LISTEN, OP_CONNECT: begin
        s = -1;
        for (int i = 0; i < Slots; i++) if (!conn_used[i] && s < 0) s = i;
        if (s < 0) stt = ST_FULL;
        else begin
          conn_used[s] = 1'b1;
          conn_rec[s] = '0;
          conn_rec[s].lip = r.lip;
          conn_rec[s].lport = r.lport;
          if (r.op == OP_LISTEN) conn_st[s] = CS_LISTEN;
          else begin
            conn_rec[s].rip = r.rip;
            conn_rec[s].rport = r.rport;
            conn_rec[s].iss = next_isn();
            conn_rec[s].snd_una = conn_rec[s].iss;
            conn_rec[s].snd_nxt = conn_rec[s].iss;
            conn_st[s] = CS_SYN_SENT;
            send_ctl(s, FlSyn);
          end
          cs = s[2:0];
          ns = conn_st[s];
        end
      end
      default: begin
        cs = r.slot;
        if (!conn_used[r.slot]) stt = ST_UNUSED;
        else begin
          case (conn_st[r.slot])
            CS_ESTAB: begin
              conn_st[r.slot] = CS_FIN_WAIT_1;
              send_ctl(r.slot, FlFin | FlAck);
            end
            CS_CLOSE_WAIT: begin
              conn_st[r.slot] = CS_LAST_ACK;
              send_ctl(r.slot, FlFin | FlAck);
            end
            CS_SYN_SENT, CS_SYN_RCVD, CS_LISTEN: conn_st[r.slot] = CS_CLOSED;
            default: ;
          endcase
          ns = conn_st[r.slot];
        end
      end
    endcase
    n = (ctl_out.size() > 0) ? ctl_out.size() : 1;
    for (int k = 0; k < n; k++) begin
      e.status = stt;
      e.slot = cs;
      e.nstate = ns;
      e.snd = (k < ctl_out.size());
      e.seg = e.snd ? ctl_out[k] : '0;
      e.last = (k == n - 1);
      expected_results.push_back(e);
    end
  endfunction

  // offer one item in bursts with random gaps; returns after the falling edge
  task automatic send_item(req_t r);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= r.op;
    local_ip_i    <= r.lip;
    local_port_i  <= r.lport;
    remote_ip_i   <= r.rip;
    remote_port_i <= r.rport;
    seg_seq_i     <= r.seq;
    seg_ack_i     <= r.ack;
    seg_flags_i   <= r.flags;
    seg_len_i     <= r.len;
    slot_i        <= r.slot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_results(r);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // wait until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic req_t rand_req(op_e op);
    req_t r;
    r.op = op;
    r.lip = $urandom;
    r.lport = 16'($urandom);
    r.rip = $urandom;
    r.rport = 16'($urandom);
    r.seq = $urandom;
    r.ack = $urandom;
    r.flags = 8'($urandom);
    r.len = 16'($urandom);
    r.slot = 3'($urandom);
    return r;
  endfunction

  // segment from the peer of slot s; a listener gets a fresh peer
  function automatic req_t peer_seg(int s, logic [7:0] fl, logic [15:0] len);
    req_t r;
    r = rand_req(OP_SEGMENT);
    r.lport = conn_rec[s].lport;
    if (conn_rec[s].lip != 0) r.lip = conn_rec[s].lip;
    if (conn_st[s] != CS_LISTEN) begin
      r.rip = conn_rec[s].rip;
      r.rport = conn_rec[s].rport;
    end
    if ($urandom_range(0, 7) == 0) r.seq = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    else if ($urandom_range(0, 1) == 0) r.seq = conn_rec[s].rcv_nxt;
    r.flags = fl | (8'($urandom) & 8'hEC);
    r.len = len;
    return r;
  endfunction

  function automatic req_t close_req(int s);
    req_t r;
    r = rand_req(OP_CLOSE);
    r.slot = s[2:0];
    return r;
  endfunction

  function automatic req_t open_req(op_e op);
    req_t r;
    r = rand_req(op);
    if ($urandom_range(0, 9) == 0) r.lip = '0;
    return r;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < Slots; i++) if (!conn_used[i]) return i;
    return -1;
  endfunction

  function automatic int used_count();
    int c;
    c = 0;
    for (int i = 0; i < Slots; i++) if (conn_used[i]) c++;
    return c;
  endfunction

  // unrelated traffic: stray segments and closes of idle slots
  task automatic send_noise();
    int f;
    f = first_free();
    if ($urandom_range(0, 1) == 0 || f < 0) send_item(rand_req(OP_SEGMENT));
    else send_item(close_req(f));
  endtask

  // walk slot s through a connection until it is freed or parked
  task automatic run_conn(int s, bit may_park);
    int steps;
    int data_rounds;
    logic [7:0] fl;
    steps = 0;
    data_rounds = $urandom_range(0, 3);
    while (conn_used[s] && steps < 40) begin
      steps++;
      if ($urandom_range(0, 9) == 0) send_noise();
      case (conn_st[s])
        CS_LISTEN: begin
          if (may_park && $urandom_range(0, 3) == 0) send_item(close_req(s));
          else send_item(peer_seg(s, FlSyn, 16'($urandom_range(0, 3))));
        end
        CS_SYN_SENT: begin
          if (may_park && $urandom_range(0, 3) == 0) send_item(close_req(s));
          else if ($urandom_range(0, 3) == 0) send_item(peer_seg(s, FlSyn, 16'd0));
          else send_item(peer_seg(s, FlSyn | FlAck, 16'd0));
        end
        CS_SYN_RCVD: begin
          if (may_park && $urandom_range(0, 3) == 0) send_item(close_req(s));
          else send_item(peer_seg(s, FlAck, 16'd0));
        end
        CS_ESTAB: begin
          if (may_park && $urandom_range(0, 2) == 0) send_item(close_req(s));
          else if (data_rounds > 0) begin
            data_rounds--;
            send_item(peer_seg(s, FlAck, ($urandom_range(0, 5) == 0) ? 16'hFFFF :
                                         16'($urandom_range(1, 1460))));
          end else begin
            send_item(peer_seg(s, FlFin | FlAck, $urandom_range(0, 1) ? 16'd0 :
                                                 16'($urandom_range(1, 900))));
          end
        end
        CS_CLOSE_WAIT: send_item(close_req(s));
        CS_LAST_ACK: send_item(peer_seg(s, FlAck, 16'd0));
        CS_FIN_WAIT_1: begin
          case ($urandom_range(0, 2))
            0: fl = FlAck;
            1: fl = FlFin;
            default: fl = FlFin | FlAck;
          endcase
          send_item(peer_seg(s, fl, 16'd0));
        end
        CS_FIN_WAIT_2: send_item(peer_seg(s, FlFin | FlAck, 16'd0));
        CS_CLOSING: send_item(peer_seg(s, FlAck, 16'd0));
        default: return;
      endcase
    end
    flows_done++;
  endtask

  // closes of idle slots, stray segments, field extremes
  task automatic test_unused_and_stray();
    req_t r;
    send_item(close_req(0));
    send_item(close_req(Slots - 1));
    r = rand_req(OP_SEGMENT);
    r.lip = '1; r.lport = '1; r.rip = '1; r.rport = '1;
    r.seq = '1; r.ack = '1; r.flags = '1; r.len = '1; r.slot = '1;
    send_item(r);
    r.lip = '0; r.lport = '0; r.rip = '0; r.rport = '0;
    r.seq = '0; r.ack = '0; r.flags = '0; r.len = '0; r.slot = '0;
    send_item(r);
    drain();
  endtask

  // wildcard and bound listeners on one port, binding without a syn
  task automatic test_listeners();
    req_t r;
    int wild;
    int bound;
    wild = first_free();
    r = rand_req(OP_LISTEN);
    r.lip = '0; r.lport = 16'd80;
    send_item(r);
    bound = first_free();
    r.lip = 32'h0A00_0001;
    send_item(r);
    // both listeners match: the higher slot wins
    r = rand_req(OP_SEGMENT);
    r.lip = 32'h0A00_0001; r.lport = 16'd80; r.flags = FlSyn; r.len = '0;
    send_item(r);
    // only the wildcard matches: it binds without leaving listen
    r = rand_req(OP_SEGMENT);
    r.lip = 32'h0A00_0002; r.lport = 16'd80; r.flags = FlAck;
    send_item(r);
    run_conn(bound, 1'b0);
    run_conn(wild, 1'b0);
    drain();
  endtask

  // connect answered by a bare syn, then data with fin in one segment
  task automatic test_simultaneous_open();
    int s;
    s = first_free();
    send_item(open_req(OP_CONNECT));
    send_item(peer_seg(s, FlSyn, 16'd0));
    send_item(peer_seg(s, FlAck, 16'd0));
    send_item(peer_seg(s, FlFin | FlAck, 16'd100));
    run_conn(s, 1'b0);
    drain();
  endtask

  // fill every slot, then listen and connect find no room
  task automatic test_table_full();
    req_t r;
    for (int i = 0; i < Slots; i++) begin
      r = open_req(OP_CONNECT);
      r.rport = 16'(1000 + i);
      if (i == 0) begin r.lip = '1; r.lport = '1; r.rip = '0; end
      send_item(r);
    end
    send_item(open_req(OP_CONNECT));
    send_item(open_req(OP_LISTEN));
    for (int i = 0; i < Slots; i++) run_conn(i, 1'b0);
    drain();
  endtask

  // receiver holds off while items keep coming
  task automatic test_hold_off();
    hold_cycles = 300;
    repeat (12) send_noise();
    drain();
  endtask

  // mostly complete connections with random content, some parked
  task automatic test_random_flows();
    int s;
    int start;
    bit park;
    start = items_sent;
    while (items_sent - start < RandomItems) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else begin
        s = first_free();
        park = (used_count() < Slots - 2) &&
               (items_sent - start > (used_count() + 1) * 200) &&
               ($urandom_range(0, 1) == 0);
        send_item(open_req($urandom_range(0, 1) ? OP_LISTEN : OP_CONNECT));
        if (s >= 0) run_conn(s, park);
      end
    end
    // fill what is left so the full table shows up again
    while (first_free() >= 0) send_item(open_req(OP_LISTEN));
    send_item(open_req(OP_CONNECT));
    drain();
  endtask

  // receiver stall pattern, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= (cycle_count % 3 == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: status %0d slot %0d state %0d",
                   status_o, conn_slot_o, new_state_o);
      end else begin
        e = expected_results.pop_front();
        if (e.snd) segs_seen++;
        if (status_o !== e.status || conn_slot_o !== e.slot ||
            new_state_o !== e.nstate || send_o !== e.snd ||
            send_flags_o !== e.seg.flags || send_seq_o !== e.seg.seq ||
            send_ack_o !== e.seg.ack || out_local_ip_o !== e.seg.lip ||
            out_local_port_o !== e.seg.lport || out_remote_ip_o !== e.seg.rip ||
            out_remote_port_o !== e.seg.rport || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp st %0d slot %0d cs %0d send %0d fl %h seq %h ack %h",
                     e.status, e.slot, e.nstate, e.snd, e.seg.flags, e.seg.seq,
                     e.seg.ack);
            $display("          exp %h:%h -> %h:%h last %0d", e.seg.lip, e.seg.lport,
                     e.seg.rip, e.seg.rport, e.last);
            $display("          got st %0d slot %0d cs %0d send %0d fl %h seq %h ack %h",
                     status_o, conn_slot_o, new_state_o, send_o, send_flags_o,
                     send_seq_o, send_ack_o);
            $display("          got %h:%h -> %h:%h last %0d", out_local_ip_o,
                     out_local_port_o, out_remote_ip_o, out_remote_port_o, last_o);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tcp_connection_state_engine test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < Slots; i++) begin
      conn_used[i] = 1'b0;
      conn_st[i] = CS_CLOSED;
      conn_rec[i] = '0;
    end
    isn_counter = IssReset;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_unused_and_stray();
    test_listeners();
    test_simultaneous_open();
    test_table_full();
    test_hold_off();
    test_random_flows();
    $display("covered %0d items, %0d result items, %0d outgoing segments",
             items_sent, results_seen, segs_seen);
    $display("%0d connections walked, %0d slots left parked", flows_done, used_count());
    if (mismatches == 0) begin
      $display("tcp_connection_state_engine test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tcp_connection_state_engine test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tcse_pkg.sv
design/tcse_conn_mem.sv
design/tcse_match.sv
design/tcp_connection_state_engine.sv
bench/tb.sv
